FILE: src/ffva_pkg.sv
package ffva_pkg;

	localparam int HDR_W      = 17;
	localparam int WB_SHIFT   = 3;
	localparam int WORD_BYTES = 8;
	localparam int CFG_W      = 13;
	localparam int REQ_W      = 16;
	localparam int OFF_W      = 15;
	localparam int LRG_W      = 16;
	localparam int STAT_W     = 2;
	localparam logic [CFG_W-1:0] CFG_RESET = 13'd4096;

	typedef enum logic [1:0] {
		OP_INIT    = 2'd0,
		OP_ALLOC   = 2'd1,
		OP_FREE    = 2'd2,
		OP_LARGEST = 2'd3
	} op_t;

	localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
	localparam logic [STAT_W-1:0] ST_NOSPACE = 2'd1;
	localparam logic [STAT_W-1:0] ST_SMALL   = 2'd2;

endpackage

FILE: src/ffva_ram.sv
module ffva_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: src/first_fit_variable_allocator_top.sv
// channel   | direction | payload
// s_axis    | in        | tuser: operation; tdata: request_bytes, chunk_offset
// m_axis    | out       | tdata: status, payload_offset, largest_bytes
// cfg       | in        | cfg_we / cfg_wdata: pool_words
//
// Init and free do not walk the chain; alloc and largest walk the header chain in
// the header RAM (one read port, one write port), reading then evaluating each
// header visited. Alloc costs up to three walks (fit, coalesce, fit again).
// Reset clears control state only; the RAM needs no clearing pass.
// A new transaction is taken once the walker is idle, even with a result held.
module first_fit_variable_allocator_top
	import ffva_pkg::*;
#(
	parameter int POOL_WORDS = 4096
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [CFG_W-1:0]           cfg_wdata,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	input  logic [31:0]                s_axis_tdata,  // request_bytes, chunk_offset
	input  logic [1:0]                 s_axis_tuser,  // operation
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	output logic [39:0]                m_axis_tdata   // status, payload_offset, largest_bytes
);

	localparam int AW = $clog2(POOL_WORDS);
	localparam int IW = ((AW > 14) ? AW : 14) + 2;
	localparam int BW = IW + WB_SHIFT + 1;

	typedef enum logic [3:0] {
		S_IDLE, S_FF_RD, S_FF_EV, S_FF_SPLIT, S_CO_RD, S_CO_EV, S_CO_END,
		S_FREE_EV, S_RESP
	} state_t;

	state_t             st_q;
	op_t                op_q;
	logic [HDR_W-1:0]   n_q;
	logic [IW-1:0]      idx_q;
	logic [AW-1:0]      start_q;
	logic [BW-1:0]      run_q;
	logic               in_run_q;
	logic [HDR_W-1:0]   best_q;
	logic               retried_q;
	logic [AW-1:0]      wa_q;
	logic [HDR_W-1:0]   split_val_q;
	logic [IW-1:0]      active_q;
	logic               ready_q;
	logic [CFG_W-1:0]   pool_q;
	logic [STAT_W-1:0]  r_stat_q;
	logic [OFF_W-1:0]   r_pay_q;
	logic [LRG_W-1:0]   r_lrg_q;
	logic               m_valid_q;
	logic [39:0]        m_data_q;

	logic               ram_we, ram_re;
	logic [AW-1:0]      ram_waddr, ram_raddr;
	logic [HDR_W-1:0]   ram_wdata, rdata;

	ffva_ram #(.WIDTH(HDR_W), .DEPTH(POOL_WORDS)) u_hdr_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (rdata)
	);

	op_t               in_op;
	logic [REQ_W-1:0]  in_req;
	logic [OFF_W-1:0]  in_off;
	logic              s_acc;
	logic [HDR_W-1:0]  n_in;
	logic [IW-1:0]     clamp_w;
	logic [11:0]       w_free;
	logic              free_ok;
	logic              v_neg;
	logic [HDR_W-1:0]  mag;
	logic [IW-1:0]     idx_adv;
	logic              ff_more;
	logic              fit;
	logic [IW-1:0]     rest;
	logic              split;
	logic [HDR_W-1:0]  run_hdr;
	logic [BW-1:0]     run_add;
	logic [HDR_W-1:0]  best_cand;

	assign in_op   = op_t'(s_axis_tuser);
	assign in_req  = s_axis_tdata[REQ_W-1:0];
	assign in_off  = s_axis_tdata[REQ_W+OFF_W-1:REQ_W];
	assign s_axis_tready = (st_q == S_IDLE);
	assign s_acc   = s_axis_tvalid && s_axis_tready;

	assign n_in    = ({1'b0, in_req} + HDR_W'(7)) & ~HDR_W'(7);
	assign clamp_w = (IW'(pool_q) > IW'(POOL_WORDS)) ? IW'(POOL_WORDS) : IW'(pool_q);
	assign w_free  = in_off[OFF_W-1:WB_SHIFT];
	assign free_ok = (w_free != 12'd0) && (IW'(w_free - 12'd1) < active_q);

	assign v_neg   = rdata[HDR_W-1];
	assign mag     = v_neg ? (~rdata + HDR_W'(1)) : rdata;
	assign idx_adv = idx_q + IW'(mag >> WB_SHIFT) + IW'(1);
	assign ff_more = (idx_q < active_q) &&
		(BW'({idx_q, 3'b000}) + BW'(n_q) < BW'({active_q, 3'b000}));
	assign fit     = $signed({rdata[HDR_W-1], rdata}) >= $signed({1'b0, n_q});
	assign rest    = idx_q + IW'(1) + IW'(n_q >> WB_SHIFT);
	assign split   = (rdata > n_q) && (rest < IW'(POOL_WORDS));
	assign run_hdr = HDR_W'(run_q - BW'(WORD_BYTES));
	assign run_add = (in_run_q ? run_q : BW'(0)) + BW'(rdata) + BW'(WORD_BYTES);
	// header of a closed run competes for the largest size
	assign best_cand = ($signed(run_hdr) > $signed(best_q)) ? run_hdr : best_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = '0;
		case (st_q)
			S_IDLE: begin
				if (s_acc && in_op == OP_INIT && clamp_w >= IW'(2)) begin
					ram_we    = 1'b1;
					ram_wdata = HDR_W'((clamp_w - IW'(1)) << WB_SHIFT);
				end else if (s_acc && in_op == OP_FREE && ready_q && free_ok) begin
					ram_re    = 1'b1;
					ram_raddr = AW'(w_free - 12'd1);
				end
			end
			S_FF_RD: begin
				if (ff_more) begin
					ram_re    = 1'b1;
					ram_raddr = idx_q[AW-1:0];
				end
			end
			S_FF_EV: begin
				if (fit) begin
					ram_we    = 1'b1;
					ram_waddr = idx_q[AW-1:0];
					ram_wdata = ~n_q + HDR_W'(1);
				end
			end
			S_FF_SPLIT: begin
				ram_we    = 1'b1;
				ram_waddr = wa_q;
				ram_wdata = split_val_q;
			end
			S_CO_RD: begin
				if (idx_q < active_q) begin
					ram_re    = 1'b1;
					ram_raddr = idx_q[AW-1:0];
				end else if (in_run_q) begin
					ram_we    = 1'b1;
					ram_waddr = start_q;
					ram_wdata = run_hdr;
				end
			end
			S_CO_EV: begin
				if (v_neg && in_run_q) begin
					ram_we    = 1'b1;
					ram_waddr = start_q;
					ram_wdata = run_hdr;
				end
			end
			S_FREE_EV: begin
				if (v_neg) begin
					ram_we    = 1'b1;
					ram_waddr = wa_q;
					ram_wdata = mag;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= S_IDLE;
			ready_q   <= 1'b0;
			active_q  <= '0;
			pool_q    <= CFG_RESET;
			m_valid_q <= 1'b0;
			in_run_q  <= 1'b0;
			retried_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				pool_q <= cfg_wdata;
			end
			if (m_valid_q && m_axis_tready && st_q != S_RESP) begin
				m_valid_q <= 1'b0;
			end
			case (st_q)
				S_IDLE: begin
					if (s_acc) begin
						op_q      <= in_op;
						n_q       <= n_in;
						idx_q     <= '0;
						retried_q <= 1'b0;
						in_run_q  <= 1'b0;
						best_q    <= '0;
						r_stat_q  <= ST_OK;
						r_pay_q   <= '0;
						r_lrg_q   <= '0;
						wa_q      <= AW'(w_free - 12'd1);
						st_q      <= S_RESP;
						if (in_op == OP_INIT) begin
							if (clamp_w < IW'(2)) begin
								ready_q  <= 1'b0;
								active_q <= '0;
								r_stat_q <= ST_SMALL;
							end else begin
								ready_q  <= 1'b1;
								active_q <= clamp_w;
							end
						end else if (!ready_q) begin
							r_stat_q <= ST_NOSPACE;
						end else if (in_op == OP_ALLOC) begin
							st_q <= S_FF_RD;
						end else if (in_op == OP_FREE) begin
							if (free_ok) begin
								st_q <= S_FREE_EV;
							end
						end else begin
							st_q <= S_CO_RD;
						end
					end
				end
				S_FF_RD: begin
					if (ff_more) begin
						st_q <= S_FF_EV;
					end else if (retried_q) begin
						r_stat_q <= ST_NOSPACE;
						st_q     <= S_RESP;
					end else begin
						idx_q <= '0;
						st_q  <= S_CO_RD;
					end
				end
				S_FF_EV: begin
					if (fit) begin
						r_pay_q     <= OFF_W'((idx_q + IW'(1)) << WB_SHIFT);
						wa_q        <= rest[AW-1:0];
						split_val_q <= HDR_W'(rdata - n_q - HDR_W'(WORD_BYTES));
						st_q        <= split ? S_FF_SPLIT : S_RESP;
					end else begin
						idx_q <= idx_adv;
						st_q  <= S_FF_RD;
					end
				end
				S_FF_SPLIT: begin
					st_q <= S_RESP;
				end
				S_CO_RD: begin
					if (idx_q < active_q) begin
						st_q <= S_CO_EV;
					end else begin
						if (in_run_q) begin
							best_q <= best_cand;
						end
						in_run_q <= 1'b0;
						st_q     <= S_CO_END;
					end
				end
				S_CO_EV: begin
					if (v_neg) begin
						if (in_run_q) begin
							best_q <= best_cand;
						end
						in_run_q <= 1'b0;
					end else begin
						if (!in_run_q) begin
							start_q <= idx_q[AW-1:0];
						end
						run_q    <= run_add;
						in_run_q <= 1'b1;
					end
					idx_q <= idx_adv;
					st_q  <= S_CO_RD;
				end
				S_CO_END: begin
					if (op_q == OP_LARGEST) begin
						r_lrg_q <= LRG_W'(best_q);
						st_q    <= S_RESP;
					end else if ((n_q + HDR_W'(WORD_BYTES)) < best_q) begin
						idx_q     <= '0;
						retried_q <= 1'b1;
						st_q      <= S_FF_RD;
					end else begin
						r_stat_q <= ST_NOSPACE;
						st_q     <= S_RESP;
					end
				end
				S_FREE_EV: begin
					st_q <= S_RESP;
				end
				S_RESP: begin
					if (!m_valid_q || m_axis_tready) begin
						m_valid_q <= 1'b1;
						m_data_q  <= {7'd0, r_lrg_q, r_pay_q, r_stat_q};
						st_q      <= S_IDLE;
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re && ram_waddr == ram_raddr))
		else $error("header read and write hit the same entry");

	a_read_in_pool: assert property (@(posedge clk) disable iff (!arst_n)
		ram_re |-> (IW'(ram_raddr) < active_q))
		else $error("header read outside the active pool");

	a_not_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!ready_q |-> (active_q == '0))
		else $error("active size set on an uninitialised pool");

	a_walk_only_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_FF_RD || st_q == S_CO_RD) |-> ready_q)
		else $error("header walk on an uninitialised pool");

endmodule
